// File: hw/rtl/tagged_value_stream_parser_top_defines.svh
// Assertion macros for the tagged value stream parser checkers.
// Used by tvsp_checker.sv; expects clk and rst_n in the including scope.
`ifndef TAGGED_VALUE_STREAM_PARSER_TOP_DEFINES_SVH
`define TAGGED_VALUE_STREAM_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TVSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tvsp same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TVSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tvsp next-cycle check failed");

`endif

// File: hw/rtl/tvsp_pkg.sv
// Shared types and codes of the tagged value stream parser.
// No dependencies; imported by the top level, the checker and the testbench.
`default_nettype none

package tvsp_pkg;

  localparam int unsigned DATA_W   = 8;
  localparam int unsigned SCALAR_W = 64;
  localparam int unsigned LEN_W    = 32;

  // Event codes
  localparam logic [1:0] EV_SCALAR  = 2'd0;
  localparam logic [1:0] EV_HEADER  = 2'd1;
  localparam logic [1:0] EV_PAYLOAD = 2'd2;
  localparam logic [1:0] EV_ERROR   = 2'd3;

  // Type tags
  localparam logic [2:0] TAG_NULL   = 3'd0;
  localparam logic [2:0] TAG_INT64  = 3'd1;
  localparam logic [2:0] TAG_DOUBLE = 3'd2;
  localparam logic [2:0] TAG_STRING = 3'd3;
  localparam logic [2:0] TAG_BYTES  = 3'd4;
  localparam logic [2:0] TAG_BOOL   = 3'd5;

  // Error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN    = 3'd1;
  localparam logic [2:0] ERR_TRUNC_SCAL = 3'd2;
  localparam logic [2:0] ERR_TRUNC_LEN  = 3'd3;
  localparam logic [2:0] ERR_TRUNC_PAY  = 3'd4;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          event_res;
    logic [2:0]          value_type;
    logic [SCALAR_W-1:0] scalar_bits;
    logic [LEN_W-1:0]    value_length;
    logic [DATA_W-1:0]   payload_byte;
    logic                payload_last;
    logic [2:0]          error_code;
    logic                buffer_end;
  } out_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/tvsp_stream_if.sv
// Valid/ready stream channel carrying one item of type payload_t.
// Depends on nothing; the payload type is set where the channel is instantiated.
`default_nettype none

interface tvsp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tagged_value_stream_parser_top.sv
// Tagged value stream parser: one byte in per cycle, at most one event out per byte.
// Takes one input byte per clock whenever the result register is free or is being
// drained in the same cycle: the whole decode of a byte (tag check, 8-byte gather,
// 32-bit payload countdown) settles between the parser state registers and the
// result register, so throughput is one byte per cycle and the event appears on
// out_ch in the cycle after the byte is accepted. in_ch.ready is the result
// register's free flag, so it follows out_ch.ready in the same cycle. Bytes that
// cause no event (tag bytes of multi-byte values, inner scalar and length bytes,
// bytes skipped after an unknown tag) pass without touching the result register.
// Channels use tvsp_pkg::in_item_t and tvsp_pkg::out_item_t as payload types.
`default_nettype none

module tagged_value_stream_parser_top
  import tvsp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  tvsp_stream_if.sink   in_ch,
  tvsp_stream_if.source out_ch
);

  // Parser phases
  localparam logic [1:0] PH_TAG     = 2'd0;
  localparam logic [1:0] PH_SCALAR  = 2'd1;
  localparam logic [1:0] PH_LENGTH  = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  logic [1:0]          phase_r, phase_nxt;
  logic [2:0]          cur_type_r, cur_type_nxt;
  logic [3:0]          cnt_r, cnt_nxt;
  logic [SCALAR_W-1:0] gather_r, gather_nxt;
  logic [LEN_W-1:0]    remain_r, remain_nxt;
  logic                discard_r, discard_nxt;

  logic                out_valid_r;
  out_item_t           out_item_r;

  logic                accept;
  logic                res_vld;
  out_item_t           res;

  logic [DATA_W-1:0]   b;
  logic                last;
  logic [SCALAR_W-1:0] gath_new;
  logic [3:0]          cnt_inc;
  logic [3:0]          need;
  logic [LEN_W-1:0]    remain_dec;
  logic [LEN_W-1:0]    len_val;

  // Result register is free when empty or being drained this cycle.
  assign in_ch.ready    = !out_valid_r || out_ch.ready;
  assign accept         = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_item_r;

  assign b          = in_ch.payload.data_byte;
  assign last       = in_ch.payload.last_byte;
  assign cnt_inc    = cnt_r + 4'd1;
  assign remain_dec = remain_r - {{(LEN_W-1){1'b0}}, 1'b1};
  assign len_val    = gath_new[LEN_W-1:0];

  // Drop the incoming byte into its little-endian lane of the gather register.
  always_comb begin
    gath_new = gather_r;
    gath_new[{cnt_r[2:0], 3'b000} +: DATA_W] = b;
  end

  // Bytes still needed: 4 for a length, 1 for a bool, 8 for other scalars.
  always_comb begin
    if (phase_r == PH_LENGTH) begin
      need = 4'd4;
    end else if (cur_type_r == TAG_BOOL) begin
      need = 4'd1;
    end else begin
      need = 4'd8;
    end
  end

  // Decode of one byte against the parser state.
  always_comb begin
    phase_nxt    = phase_r;
    cur_type_nxt = cur_type_r;
    cnt_nxt      = cnt_r;
    gather_nxt   = gather_r;
    remain_nxt   = remain_r;
    discard_nxt  = discard_r;
    res_vld      = 1'b0;
    res          = '0;
    res.buffer_end = last;

    if (discard_r) begin
      // Skip silently until the buffer ends, then expect a tag.
      if (last) begin
        discard_nxt = 1'b0;
        phase_nxt   = PH_TAG;
        cnt_nxt     = '0;
        gather_nxt  = '0;
        remain_nxt  = '0;
      end
    end else begin
      unique case (phase_r) inside
        PH_TAG: begin
          res.value_type = b[2:0];
          if (b == {DATA_W{1'b0}}) begin
            // Null value completes on its tag.
            cur_type_nxt  = TAG_NULL;
            res_vld       = 1'b1;
            res.event_res = EV_SCALAR;
          end else if (b > {5'd0, TAG_BOOL}) begin
            // Unknown tag: report, then skip the rest of the buffer.
            res_vld        = 1'b1;
            res.event_res  = EV_ERROR;
            res.value_type = TAG_NULL;
            res.error_code = ERR_UNKNOWN;
            discard_nxt    = !last;
            cnt_nxt        = '0;
            gather_nxt     = '0;
            remain_nxt     = '0;
          end else begin
            cur_type_nxt = b[2:0];
            cnt_nxt      = '0;
            gather_nxt   = '0;
            if (last) begin
              res_vld        = 1'b1;
              res.event_res  = EV_ERROR;
              res.error_code = (b[2:0] == TAG_STRING || b[2:0] == TAG_BYTES) ?
                               ERR_TRUNC_LEN : ERR_TRUNC_SCAL;
              remain_nxt     = '0;
            end else if (b[2:0] == TAG_STRING || b[2:0] == TAG_BYTES) begin
              phase_nxt = PH_LENGTH;
            end else begin
              phase_nxt = PH_SCALAR;
            end
          end
        end

        PH_SCALAR, PH_LENGTH: begin
          res.value_type = cur_type_r;
          gather_nxt     = gath_new;
          cnt_nxt        = cnt_inc;
          if (cnt_inc >= need) begin
            res_vld    = 1'b1;
            phase_nxt  = PH_TAG;
            cnt_nxt    = '0;
            gather_nxt = '0;
            remain_nxt = '0;
            if (phase_r == PH_SCALAR) begin
              res.event_res   = EV_SCALAR;
              res.scalar_bits = gath_new;
            end else if (len_val == {LEN_W{1'b0}}) begin
              // Empty string or byte vector: header only.
              res.event_res = EV_HEADER;
            end else if (last) begin
              res.event_res  = EV_ERROR;
              res.error_code = ERR_TRUNC_PAY;
            end else begin
              res.event_res    = EV_HEADER;
              res.value_length = len_val;
              phase_nxt        = PH_PAYLOAD;
              remain_nxt       = len_val;
            end
          end else if (last) begin
            res_vld        = 1'b1;
            res.event_res  = EV_ERROR;
            res.error_code = (phase_r == PH_LENGTH) ? ERR_TRUNC_LEN : ERR_TRUNC_SCAL;
            phase_nxt      = PH_TAG;
            cnt_nxt        = '0;
            gather_nxt     = '0;
            remain_nxt     = '0;
          end
        end

        PH_PAYLOAD: begin
          res_vld        = 1'b1;
          res.value_type = cur_type_r;
          remain_nxt     = remain_dec;
          if (remain_dec == {LEN_W{1'b0}}) begin
            res.event_res    = EV_PAYLOAD;
            res.payload_byte = b;
            res.payload_last = 1'b1;
            phase_nxt        = PH_TAG;
            cnt_nxt          = '0;
            gather_nxt       = '0;
          end else if (last) begin
            // Buffer ended inside the payload.
            res.event_res  = EV_ERROR;
            res.error_code = ERR_TRUNC_PAY;
            phase_nxt      = PH_TAG;
            cnt_nxt        = '0;
            gather_nxt     = '0;
            remain_nxt     = '0;
          end else begin
            res.event_res    = EV_PAYLOAD;
            res.payload_byte = b;
          end
        end

        default: begin
          phase_nxt = PH_TAG;
        end
      endcase
    end
  end

  // Parser state: advance only on an accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_TAG;
      cur_type_r <= TAG_NULL;
      cnt_r      <= '0;
      gather_r   <= '0;
      remain_r   <= '0;
      discard_r  <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      cur_type_r <= cur_type_nxt;
      cnt_r      <= cnt_nxt;
      gather_r   <= gather_nxt;
      remain_r   <= remain_nxt;
      discard_r  <= discard_nxt;
    end
  end

  // Result register: load on an event, clear once taken, hold while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept && res_vld) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_vld) begin
      out_item_r <= res;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tvsp_checker.sv
// Port-level checks for the tagged value stream parser, bound to the top level.
// Depends on tvsp_pkg and the assertion macros in the defines header.
`default_nettype none
`include "tagged_value_stream_parser_top_defines.svh"

module tvsp_checker
  import tvsp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  // A stalled event holds its contents.
  `TVSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

  // Only error events carry an error code.
  `TVSP_ASSERT_NOW(a_err_code, out_valid && out_item.event_res != EV_ERROR,
                   out_item.error_code == ERR_NONE)

  // Payload and error events carry no scalar bits and no length.
  `TVSP_ASSERT_NOW(a_payload_clean,
                   out_valid && (out_item.event_res == EV_PAYLOAD ||
                                 out_item.event_res == EV_ERROR),
                   out_item.scalar_bits == '0 && out_item.value_length == '0)

  // The final-payload flag appears only on payload events.
  `TVSP_ASSERT_NOW(a_last_on_payload, out_valid && out_item.payload_last,
                   out_item.event_res == EV_PAYLOAD)

endmodule

bind tagged_value_stream_parser_top tvsp_checker u_tvsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.payload)
);

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for the tagged value stream parser.
// Depends on tvsp_pkg, tvsp_stream_if and tagged_value_stream_parser_top.
// A directed table runs first, then random buffers; expected events come from a built-in decoder or a typed table row.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tvsp_pkg::*;

  // Random part length in bytes that the parser actually looks at.
  localparam int RANDOM_BYTES = 800;
  // Bytes at the end of the random part sent with no idling on either side.
  localparam int CALM_TAIL    = 120;
  // Worst correct stretch with no handshake is about one send gap plus one result
  // stall plus the pass through the result register; allow many times that.
  localparam int STALL_LIMIT  = 400;
  // Cycles to wait, after the last owed event, for stray events from the result register.
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {AT_TAG, IN_SCALAR, IN_LENGTH, IN_PAYLOAD} parse_phase_t;

  // One row of the directed table. Where typed is set, the expected event is
  // given here; otherwise it comes from the decoder below.
  typedef struct {
    logic [7:0]  data;
    logic        last;
    bit          typed;
    logic [1:0]  ev;
    logic [2:0]  ty;
    logic [63:0] bits;
    logic [31:0] len;
    logic [2:0]  err;
  } step_row_t;

  localparam int N_ROWS = 28;

  step_row_t directed_rows [N_ROWS] = '{
    // null value
    '{8'(TAG_NULL),   1'b0, 1'b1, EV_SCALAR, TAG_NULL,   '0,       '0, ERR_NONE},
    // bool with the top bit set
    '{8'(TAG_BOOL),   1'b0, 1'b0, '0,        '0,         '0,       '0, ERR_NONE},
    '{8'h80,          1'b0, 1'b1, EV_SCALAR, TAG_BOOL,   64'h80,   '0, ERR_NONE},
    // scalar tag and variable tag on the last byte
    '{8'(TAG_INT64),  1'b1, 1'b1, EV_ERROR,  TAG_INT64,  '0,       '0, ERR_TRUNC_SCAL},
    '{8'(TAG_STRING), 1'b1, 1'b1, EV_ERROR,  TAG_STRING, '0,       '0, ERR_TRUNC_LEN},
    // zero-length byte vector: header, then straight back to a tag
    '{8'(TAG_BYTES),  1'b0, 1'b0, '0,        '0,         '0,       '0, ERR_NONE},
    '{8'h00,          1'b0, 1'b0, '0,        '0,         '0,       '0, ERR_NONE},
    '{8'h00,          1'b0, 1'b0, '0,        '0,         '0,       '0, ERR_NONE},
    '{8'h00,          1'b0, 1'b0, '0,        '0,         '0,       '0, ERR_NONE},
    '{8'h00,          1'b0, 1'b1, EV_HEADER, TAG_BYTES,  '0,       '0, ERR_NONE},
    // unknown tag mid-buffer; the rest of the buffer is skipped silently
    '{8'h09,          1'b0, 1'b1, EV_ERROR,  TAG_NULL,   '0,       '0, ERR_UNKNOWN},
    '{8'(TAG_BOOL),   1'b1, 1'b0, '0,        '0,         '0,       '0, ERR_NONE},
    // unknown tag on the last byte
    '{8'hFF,          1'b1, 1'b1, EV_ERROR,  TAG_NULL,   '0,       '0, ERR_UNKNOWN},
    // buffer ends inside a scalar
    '{8'(TAG_DOUBLE), 1'b0, 1'b0, '0,        '0,         '0,       '0, ERR_NONE},
    '{8'h7F,          1'b1, 1'b1, EV_ERROR,  TAG_DOUBLE, '0,       '0, ERR_TRUNC_SCAL},
    // buffer ends inside a length
    '{8'(TAG_STRING), 1'b0, 1'b0, '0,        '0,         '0,       '0, ERR_NONE},
    '{8'h01,          1'b1, 1'b1, EV_ERROR,  TAG_STRING, '0,       '0, ERR_TRUNC_LEN},
    // nonzero length completing on the last byte
    '{8'(TAG_BYTES),  1'b0, 1'b0, '0,        '0,         '0,       '0, ERR_NONE},
    '{8'h02,          1'b0, 1'b0, '0,        '0,         '0,       '0, ERR_NONE},
    '{8'h00,          1'b0, 1'b0, '0,        '0,         '0,       '0, ERR_NONE},
    '{8'h00,          1'b0, 1'b0, '0,        '0,         '0,       '0, ERR_NONE},
    '{8'h00,          1'b1, 1'b1, EV_ERROR,  TAG_BYTES,  '0,       '0, ERR_TRUNC_PAY},
    // buffer ends on a payload byte that is not the final one
    '{8'(TAG_STRING), 1'b0, 1'b0, '0,        '0,         '0,       '0, ERR_NONE},
    '{8'h02,          1'b0, 1'b0, '0,        '0,         '0,       '0, ERR_NONE},
    '{8'h00,          1'b0, 1'b0, '0,        '0,         '0,       '0, ERR_NONE},
    '{8'h00,          1'b0, 1'b0, '0,        '0,         '0,       '0, ERR_NONE},
    '{8'h00,          1'b0, 1'b0, '0,        '0,         '0,       '0, ERR_NONE},
    '{8'hAA,          1'b1, 1'b1, EV_ERROR,  TAG_STRING, '0,       '0, ERR_TRUNC_PAY}
  };

  logic clk = 1'b0;
  logic rst_n;

  tvsp_stream_if #(.payload_t(in_item_t))  in_ch ();
  tvsp_stream_if #(.payload_t(out_item_t)) out_ch ();

  tagged_value_stream_parser_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Decoder state, mirroring the parser after reset.
  parse_phase_t parse_phase  = AT_TAG;
  logic [2:0]   value_tag    = TAG_NULL;
  logic [3:0]   gathered_cnt = '0;
  logic [63:0]  gather_bits  = '0;
  logic [31:0]  payload_left = '0;
  logic         skipping     = 1'b0;

  out_item_t  events_due [$];   // events still owed by the parser, oldest first
  logic [7:0] frame_q    [$];   // bytes of the buffer being built
  bit         idle_en    = 1'b1;

  int fail_cnt    = 0;
  int bytes_sent  = 0;
  int live_bytes  = 0;
  int n_checked   = 0;
  int n_errors    = 0;
  int n_payload   = 0;
  int n_frames    = 0;
  int idle_cycles = 0;

  task automatic back_to_tag();
    parse_phase  = AT_TAG;
    gathered_cnt = '0;
    gather_bits  = '0;
    payload_left = '0;
  endtask

  // Append one byte to the buffer being built.
  task automatic put_byte(input logic [7:0] x);
    frame_q = {frame_q, x};
  endtask

  // Advance the decoder by one byte and return the event it causes, if any.
  task automatic decode_byte(input logic [7:0] b, input logic lst,
                             output bit has_ev, output out_item_t ev);
    logic [3:0]  need;
    logic [31:0] len;
    bit          is_var;
    has_ev        = 1'b0;
    ev            = '0;
    ev.buffer_end = lst;
    if (skipping) begin
      // silently drop bytes until the buffer ends
      if (lst) begin
        skipping = 1'b0;
        back_to_tag();
      end
    end else begin
      case (parse_phase)
        AT_TAG: begin
          if (b == 8'(TAG_NULL)) begin
            value_tag      = TAG_NULL;
            has_ev         = 1'b1;
            ev.event_res   = EV_SCALAR;
            ev.value_type  = TAG_NULL;
          end else if (b > 8'(TAG_BOOL)) begin
            has_ev         = 1'b1;
            ev.event_res   = EV_ERROR;
            ev.value_type  = TAG_NULL;
            ev.error_code  = ERR_UNKNOWN;
            skipping       = !lst;
            back_to_tag();
          end else begin
            value_tag    = b[2:0];
            gathered_cnt = '0;
            gather_bits  = '0;
            is_var       = (value_tag == TAG_STRING) || (value_tag == TAG_BYTES);
            if (lst) begin
              has_ev        = 1'b1;
              ev.event_res  = EV_ERROR;
              ev.value_type = value_tag;
              ev.error_code = is_var ? ERR_TRUNC_LEN : ERR_TRUNC_SCAL;
              back_to_tag();
            end else begin
              parse_phase = is_var ? IN_LENGTH : IN_SCALAR;
            end
          end
        end
        IN_SCALAR, IN_LENGTH: begin
          if (parse_phase == IN_LENGTH) need = 4'd4;
          else need = (value_tag == TAG_BOOL) ? 4'd1 : 4'd8;
          gather_bits  = gather_bits | (64'(b) << {gathered_cnt[2:0], 3'b000});
          gathered_cnt = gathered_cnt + 4'd1;
          ev.value_type = value_tag;
          if (gathered_cnt >= need) begin
            has_ev = 1'b1;
            if (parse_phase == IN_SCALAR) begin
              ev.event_res   = EV_SCALAR;
              ev.scalar_bits = gather_bits;
              back_to_tag();
            end else begin
              len = gather_bits[31:0];
              if (len == '0) begin
                ev.event_res = EV_HEADER;
                back_to_tag();
              end else if (lst) begin
                ev.event_res  = EV_ERROR;
                ev.error_code = ERR_TRUNC_PAY;
                back_to_tag();
              end else begin
                ev.event_res    = EV_HEADER;
                ev.value_length = len;
                parse_phase     = IN_PAYLOAD;
                payload_left    = len;
                gathered_cnt    = '0;
                gather_bits     = '0;
              end
            end
          end else if (lst) begin
            has_ev        = 1'b1;
            ev.event_res  = EV_ERROR;
            ev.error_code = (parse_phase == IN_LENGTH) ? ERR_TRUNC_LEN : ERR_TRUNC_SCAL;
            back_to_tag();
          end
        end
        default: begin
          payload_left  = payload_left - 32'd1;
          has_ev        = 1'b1;
          ev.value_type = value_tag;
          if (payload_left == '0) begin
            ev.event_res    = EV_PAYLOAD;
            ev.payload_byte = b;
            ev.payload_last = 1'b1;
            back_to_tag();
          end else if (lst) begin
            ev.event_res  = EV_ERROR;
            ev.error_code = ERR_TRUNC_PAY;
            back_to_tag();
          end else begin
            ev.event_res    = EV_PAYLOAD;
            ev.payload_byte = b;
          end
        end
      endcase
    end
  endtask

  // Offer one byte, wait for it to be taken, and queue the event it owes.
  task automatic send_byte(input logic [7:0] b, input logic lst,
                           input bit typed, input out_item_t typed_ev);
    bit        has_ev;
    bit        was_skipping;
    out_item_t ev;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= {b, lst};
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    was_skipping = skipping;
    decode_byte(b, lst, has_ev, ev);
    if (typed) begin
      ev     = typed_ev;
      has_ev = 1'b1;
    end
    if (has_ev) events_due = {events_due, ev};
    if (!was_skipping) live_bytes++;
    bytes_sent++;
  endtask

  // Append one random value to the buffer; set closes when the buffer must
  // end right after it (open-ended payloads, unknown tags, noise).
  task automatic add_value(output bit closes);
    int          kind;
    int          n;
    logic [31:0] len;
    logic [2:0]  tag;
    closes = 1'b0;
    kind   = $urandom_range(0, 11);
    case (kind)
      0: put_byte(8'(TAG_NULL));
      1, 2, 3: begin
        tag = (kind == 3) ? TAG_DOUBLE : TAG_INT64;
        put_byte(8'(tag));
        repeat (8) put_byte(8'($urandom));
      end
      4, 11: begin
        put_byte(8'(TAG_BOOL));
        put_byte(8'($urandom));
      end
      5, 6, 7, 8: begin
        tag = $urandom_range(0, 1) ? TAG_STRING : TAG_BYTES;
        if (kind == 8) begin
          // random 32-bit length: the buffer nearly always runs out before the payload does
          len    = $urandom;
          n      = $urandom_range(0, 3);
          closes = 1'b1;
        end else begin
          len = $urandom_range(0, 6);
          n   = len;
        end
        put_byte(8'(tag));
        for (int i = 0; i < 4; i++) put_byte(len[8*i +: 8]);
        repeat (n) put_byte(8'($urandom));
      end
      9: begin
        put_byte(8'($urandom_range(6, 255)));
        repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
        closes = 1'b1;
      end
      default: begin
        repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
        closes = 1'b1;
      end
    endcase
  endtask

  function automatic string show(out_item_t e);
    return $sformatf("ev=%0d ty=%0d bits=%h len=%h pb=%h pl=%b err=%0d end=%b",
                     e.event_res, e.value_type, e.scalar_bits, e.value_length,
                     e.payload_byte, e.payload_last, e.error_code, e.buffer_end);
  endfunction

  task automatic note_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  // Result side: stall in random bursts while idling is allowed.
  initial begin : result_sink
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_en && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 8);
      if (idle_en && stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = 0;
      end
    end
  end

  // Check every accepted event against the oldest one owed.
  always @(posedge clk) begin : event_check
    out_item_t want;
    out_item_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = out_ch.payload;
      if (events_due.size() == 0) begin
        note_fail({"unexpected event: ", show(got)});
      end else begin
        want = events_due.pop_front();
        n_checked++;
        if (want.event_res == EV_ERROR) n_errors++;
        if (want.event_res == EV_PAYLOAD) n_payload++;
        if (got.event_res    !== want.event_res    ||
            got.value_type   !== want.value_type   ||
            got.scalar_bits  !== want.scalar_bits  ||
            got.value_length !== want.value_length ||
            got.payload_byte !== want.payload_byte ||
            got.payload_last !== want.payload_last ||
            got.error_code   !== want.error_code   ||
            got.buffer_end   !== want.buffer_end)
          note_fail({"mismatch\n  expected ", show(want), "\n  actual   ", show(got)});
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    out_item_t typed_ev;
    bit        closes;
    int        n_vals;
    int        rand_base;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table: typed rows carry their own expected event.
    for (int r = 0; r < N_ROWS; r++) begin
      typed_ev = '{event_res:    directed_rows[r].ev,
                   value_type:   directed_rows[r].ty,
                   scalar_bits:  directed_rows[r].bits,
                   value_length: directed_rows[r].len,
                   payload_byte: '0,
                   payload_last: 1'b0,
                   error_code:   directed_rows[r].err,
                   buffer_end:   directed_rows[r].last};
      send_byte(directed_rows[r].data, directed_rows[r].last,
                directed_rows[r].typed, typed_ev);
    end

    // Random buffers: mostly well-formed values, some cut short, some noise.
    rand_base = live_bytes;
    while (live_bytes - rand_base < RANDOM_BYTES) begin
      frame_q.delete();
      n_vals = $urandom_range(1, 4);
      for (int v = 0; v < n_vals; v++) begin
        add_value(closes);
        if (closes) break;
      end
      // cut the buffer anywhere to hit every truncation point
      if ($urandom_range(0, 3) == 0)
        frame_q = frame_q[0:$urandom_range(0, frame_q.size() - 1)];
      if (live_bytes - rand_base >= RANDOM_BYTES - CALM_TAIL) idle_en = 1'b0;
      foreach (frame_q[i])
        send_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, '0);
      n_frames++;
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Drain: wait for every owed event, then hold a few cycles for strays.
    while (events_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (events_due.size() != 0)
      note_fail($sformatf("%0d events never arrived", events_due.size()));

    $display("sent %0d bytes (%0d directed rows, %0d random buffers, %0d bytes decoded)",
             bytes_sent, N_ROWS, n_frames, live_bytes);
    $display("checked %0d events: %0d errors, %0d payload bytes; %0d failures",
             n_checked, n_errors, n_payload, fail_cnt);
    if (fail_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
